@@ rtl/psrs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_pkg: shared types and constants
// Transfer payloads, table entry layout and the fixed codes of the
// per-sensor running statistics block.
// ----------------------------------------------------------------------------
package psrs_pkg;

   // command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // reading kinds
   localparam logic [1:0] KIND_TEMP   = 2'd0;
   localparam logic [1:0] KIND_ENERGY = 2'd1;

   // row kinds
   localparam logic ROW_MEAN    = 1'b0;
   localparam logic ROW_SUMMARY = 1'b1;

   // saturation limits
   localparam logic signed [47:0] S48_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] S48_MIN   = 48'sh8000_0000_0000;
   localparam logic [23:0]        COUNT_MAX = 24'hFF_FFFF;
   localparam logic [31:0]        ALERT_MAX = 32'hFFFF_FFFF;
   localparam logic [22:0]        DEV_MAX   = 23'h7F_FFFF;

   typedef struct packed {
      logic              cmd;
      logic [11:0]       sensor_id;
      logic [1:0]        reading_kind;
      logic signed [23:0] reading_value;
      logic              alert_flag;
   } req_type;

   typedef struct packed {
      logic               row_kind;
      logic [9:0]         row_sensor;
      logic signed [23:0] mean_value;
      logic [22:0]        deviation;
      logic               none_unstable;
      logic [31:0]        alerts_seen;
      logic signed [47:0] energy_sum;
      logic               last;
   } rsp_type;

   // one table entry: count, sum of squares (Q16), sum (Q8)
   typedef struct packed {
      logic [23:0]        cnt;
      logic [63:0]        sq;
      logic signed [47:0] sum;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

@@ rtl/psrs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module psrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/per_sensor_running_statistics.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_sensor_running_statistics: per-sensor temperature mean and deviation
// Keeps per-sensor sum, sum of squares and count in one RAM, plus an energy
// total and an alert count, and reports means and the most unstable sensor.
// ----------------------------------------------------------------------------
// After reset the block sweeps the statistics RAM to zero, one entry a cycle,
// so req_ready stays low until the sweep ends. A record transfer does a RAM
// read, a squaring multiply and a read-modify-write; readings with
// an out-of-range id are dropped in the accept cycle. A report walks every
// sensor entry through one shared 65-bit add/subtract unit, skipping empty
// entries; an active one takes a 64-step mean divide, a 64-step sum-of-squares
// divide, a 48-step shift-add square and a 32-step square root, and the walk
// waits while the result side stalls. Mean rows come first in ascending id
// order, then the summary row with last set. req_ready is low throughout.
// ----------------------------------------------------------------------------
module per_sensor_running_statistics import psrs_pkg::*; #(
   parameter int SENSOR_SLOTS = 1024,
   parameter int MEAN_ROWS    = 10
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
   localparam int NW = $clog2(MEAN_ROWS + 2);
   localparam logic [AW-1:0] LAST_IDX = AW'(SENSOR_SLOTS - 1);

   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_REC_SQ = 4'd2;
   localparam logic [3:0] ST_REC_WR = 4'd3;
   localparam logic [3:0] ST_SC_RD  = 4'd4;
   localparam logic [3:0] ST_SC_LD  = 4'd5;
   localparam logic [3:0] ST_DIV1   = 4'd6;
   localparam logic [3:0] ST_MEAN   = 4'd7;
   localparam logic [3:0] ST_DIV2   = 4'd8;
   localparam logic [3:0] ST_MUL    = 4'd9;
   localparam logic [3:0] ST_VAR    = 4'd10;
   localparam logic [3:0] ST_SQRT   = 4'd11;
   localparam logic [3:0] ST_DEVUP  = 4'd12;
   localparam logic [3:0] ST_SUM    = 4'd13;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic signed [23:0] v_ff, v_in;
   logic [1:0]         kind_ff, kind_in;
   logic [47:0]        sqr_ff, sqr_in;
   logic signed [47:0] energy_ff, energy_in;
   logic [31:0]        alert_ff, alert_in;
   logic [NW-1:0]      nrow_ff, nrow_in;
   logic [22:0]        best_ff, best_in;
   logic [11:0]        best_id_ff, best_id_in;
   logic               found_ff, found_in;
   logic [5:0]         step_ff, step_in;
   logic [63:0]        dvd_ff, dvd_in;
   logic [23:0]        rem_ff, rem_in;
   logic [47:0]        mag_ff, mag_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        mcand_ff, mcand_in;
   logic [63:0]        bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          rd_entry, wr_entry;
   logic               ram_we;
   logic [AW-1:0]      ram_raddr;

   logic               req_fire, id_ok;
   logic [64:0]        alu_a, alu_b, alu_res;
   logic               alu_sub, alu_borrow;
   logic [24:0]        rem_sh;
   logic signed [47:0] sqr_prod;
   logic [47:0]        sum_mag;
   logic [47:0]        quo;
   logic signed [47:0] mean_c;
   logic [48:0]        tsum49, esum49;
   logic [64:0]        tsq65;
   logic [63:0]        root_c;
   logic [22:0]        dev_c;
   logic [11:0]        idx12;
   logic               last_idx;

   // statistics table
   psrs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SENSOR_SLOTS)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(idx_ff),
      .wdata(wr_entry),
      .raddr(ram_raddr),
      .rdata(rd_entry)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign id_ok     = {1'b0, req_data.sensor_id} < 13'(SENSOR_SLOTS);
   assign ram_raddr = (state_ff == ST_IDLE) ? AW'(req_data.sensor_id) : idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign idx12     = 12'(idx_ff);
   assign last_idx  = (idx_ff == LAST_IDX);

   // shared add/subtract unit
   assign alu_res    = alu_a + (alu_sub ? ~alu_b : alu_b) + 65'(alu_sub);
   assign alu_borrow = alu_res[64];
   assign rem_sh     = {rem_ff, dvd_ff[63]};

   always_comb begin
      alu_a   = 65'(acc_ff);
      alu_b   = 65'(mcand_ff);
      alu_sub = 1'b0;
      case (state_ff)
         ST_DIV1, ST_DIV2: begin
            alu_a   = 65'(rem_sh);
            alu_b   = 65'(rd_entry.cnt);
            alu_sub = 1'b1;
         end
         ST_VAR: begin
            alu_a   = 65'(dvd_ff);
            alu_b   = 65'(acc_ff);
            alu_sub = 1'b1;
         end
         ST_SQRT: begin
            alu_a   = 65'(acc_ff);
            alu_b   = 65'(mcand_ff | bit_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // record arithmetic
   assign sqr_prod = v_ff * v_ff;
   assign tsum49   = {rd_entry.sum[47], rd_entry.sum} + {{25{v_ff[23]}}, v_ff};
   assign tsq65    = {1'b0, rd_entry.sq} + 65'(sqr_ff);
   assign esum49   = {energy_ff[47], energy_ff}
                     + {{25{req_data.reading_value[23]}}, req_data.reading_value};

   always_comb begin
      wr_entry = '0;
      if (state_ff == ST_REC_WR) begin
         wr_entry.cnt = rd_entry.cnt + 24'd1;
         wr_entry.sq  = tsq65[64] ? '1 : tsq65[63:0];
         if (tsum49[48] != tsum49[47]) begin
            wr_entry.sum = tsum49[48] ? S48_MIN : S48_MAX;
         end else begin
            wr_entry.sum = tsum49[47:0];
         end
      end
   end

   assign ram_we = (state_ff == ST_CLR)
                   || (state_ff == ST_REC_WR && kind_ff == KIND_TEMP
                       && rd_entry.cnt != COUNT_MAX);

   // mean and deviation helpers
   assign sum_mag = rd_entry.sum[47] ? (~rd_entry.sum + 48'd1) : rd_entry.sum;
   assign quo     = dvd_ff[47:0];
   assign mean_c  = rd_entry.sum[47] ? (~quo + 48'd1) : quo;
   assign root_c  = mcand_ff;
   assign dev_c   = (root_c > 64'(DEV_MAX)) ? DEV_MAX : root_c[22:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      v_in         = v_ff;
      kind_in      = kind_ff;
      sqr_in       = sqr_ff;
      energy_in    = energy_ff;
      alert_in     = alert_ff;
      nrow_in      = nrow_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      found_in     = found_ff;
      step_in      = step_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         // sweep the table to zero
         ST_CLR: begin
            idx_in = idx_ff + AW'(1);
            if (last_idx) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_REPORT) begin
                  idx_in     = '0;
                  nrow_in    = '0;
                  best_in    = '0;
                  best_id_in = '0;
                  found_in   = 1'b0;
                  state_in   = ST_SC_RD;
               end else if (id_ok) begin
                  idx_in   = AW'(req_data.sensor_id);
                  v_in     = req_data.reading_value;
                  kind_in  = req_data.reading_kind;
                  state_in = ST_REC_SQ;
                  if (req_data.reading_kind == KIND_ENERGY) begin
                     if (esum49[48] != esum49[47]) begin
                        energy_in = esum49[48] ? S48_MIN : S48_MAX;
                     end else begin
                        energy_in = esum49[47:0];
                     end
                  end
                  if (req_data.alert_flag && alert_ff != ALERT_MAX) begin
                     alert_in = alert_ff + 32'd1;
                  end
               end
            end
         end
         ST_REC_SQ: begin
            sqr_in   = sqr_prod;
            state_in = ST_REC_WR;
         end
         ST_REC_WR: begin
            state_in = ST_IDLE;
         end
         ST_SC_RD: begin
            state_in = ST_SC_LD;
         end
         // skip empty entries, else start the mean divide
         ST_SC_LD: begin
            if (rd_entry.cnt == '0) begin
               idx_in   = idx_ff + AW'(1);
               state_in = last_idx ? ST_SUM : ST_SC_RD;
            end else begin
               dvd_in   = 64'(sum_mag);
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV1;
            end
         end
         // one restoring divide step per cycle
         ST_DIV1, ST_DIV2: begin
            step_in = step_ff + 6'd1;
            if (!alu_borrow) begin
               rem_in = alu_res[23:0];
            end else begin
               rem_in = rem_sh[23:0];
            end
            dvd_in = {dvd_ff[62:0], !alu_borrow};
            if (step_ff == 6'd63) begin
               step_in  = '0;
               state_in = (state_ff == ST_DIV1) ? ST_MEAN : ST_MUL;
            end
         end
         // emit a mean row while rows remain, then divide the squares
         ST_MEAN: begin
            if (nrow_ff < NW'(MEAN_ROWS)) begin
               if (!rsp_valid_ff) begin
                  rsp_in            = '0;
                  rsp_in.row_kind   = ROW_MEAN;
                  rsp_in.row_sensor = idx12[9:0];
                  rsp_in.mean_value = mean_c[23:0];
                  rsp_valid_in      = 1'b1;
                  nrow_in           = nrow_ff + NW'(1);
               end
            end
            if (nrow_ff >= NW'(MEAN_ROWS) || !rsp_valid_ff) begin
               mag_in   = quo;
               acc_in   = '0;
               mcand_in = 64'(quo);
               dvd_in   = rd_entry.sq;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV2;
            end
         end
         // shift-add square of the mean magnitude, low 64 bits
         ST_MUL: begin
            if (mag_ff[0]) begin
               acc_in = alu_res[63:0];
            end
            mcand_in = {mcand_ff[62:0], 1'b0};
            mag_in   = {1'b0, mag_ff[47:1]};
            step_in  = step_ff + 6'd1;
            if (step_ff == 6'd47) begin
               step_in  = '0;
               state_in = ST_VAR;
            end
         end
         // variance, clamped at zero
         ST_VAR: begin
            mcand_in = '0;
            bit_in   = 64'h4000_0000_0000_0000;
            step_in  = '0;
            if (!alu_borrow && alu_res[63:0] != '0) begin
               acc_in   = alu_res[63:0];
               state_in = ST_SQRT;
            end else begin
               state_in = ST_DEVUP;
            end
         end
         // one root digit per cycle
         ST_SQRT: begin
            if (!alu_borrow) begin
               acc_in   = alu_res[63:0];
               mcand_in = {1'b0, mcand_ff[63:1]} | bit_ff;
            end else begin
               mcand_in = {1'b0, mcand_ff[63:1]};
            end
            bit_in  = {2'b00, bit_ff[63:2]};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               step_in  = '0;
               state_in = ST_DEVUP;
            end
         end
         // keep the first strictly largest deviation
         ST_DEVUP: begin
            if (dev_c > best_ff) begin
               best_in    = dev_c;
               best_id_in = idx12;
               found_in   = 1'b1;
            end
            idx_in   = idx_ff + AW'(1);
            state_in = last_idx ? ST_SUM : ST_SC_RD;
         end
         ST_SUM: begin
            if (!rsp_valid_ff) begin
               rsp_in               = '0;
               rsp_in.row_kind      = ROW_SUMMARY;
               rsp_in.row_sensor    = best_id_ff[9:0];
               rsp_in.deviation     = best_ff;
               rsp_in.none_unstable = !found_ff;
               rsp_in.alerts_seen   = alert_ff;
               rsp_in.energy_sum    = energy_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               idx_in               = '0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         energy_ff    <= '0;
         alert_ff     <= '0;
         nrow_ff      <= '0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         energy_ff    <= energy_in;
         alert_ff     <= alert_in;
         nrow_ff      <= nrow_in;
         found_ff     <= found_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      kind_ff    <= kind_in;
      sqr_ff     <= sqr_in;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      mag_ff     <= mag_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      bit_ff     <= bit_in;
      rsp_ff     <= rsp_in;
   end

   // a report blocks further transfers on the next cycle
   a_report_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.cmd == CMD_REPORT |=> !req_ready)
      else $error("input accepted during report scan");

   // summary rows and only summary rows are last
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.last == rsp_ff.row_kind)
      else $error("last flag does not match row kind");

   // no unstable sensor means zero deviation and sensor
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.none_unstable
      |-> rsp_ff.deviation == '0 && rsp_ff.row_sensor == '0)
      else $error("none_unstable row carries a deviation");

   // mean rows never exceed their limit
   a_row_limit: assert property (@(posedge clock) disable iff (reset)
      nrow_ff <= NW'(MEAN_ROWS))
      else $error("too many mean rows");

endmodule
`default_nettype wire
